@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the bin mapper checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is high.
`define FLHB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define FLHB_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/flhb_pkg.sv @@
// ---------------------------------------------------------------------------
// flhb_pkg
// Types, register map and constants of the logarithmic histogram bin mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package flhb_pkg;

  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int ENTRY_W             = 10;
  localparam int MANT_W              = 23;
  localparam int S_TDATA_W           = 56;
  localparam int M_TDATA_W           = 32;
  localparam int PADDR_W             = 5;

  localparam logic [31:0] SIGN32 = 32'h8000_0000;
  localparam logic [15:0] SIGN16 = 16'h8000;
  localparam logic [4:0]  WIDTH32 = 5'd23;
  localparam logic [4:0]  WIDTH16 = 5'd10;
  localparam logic signed [9:0] BIAS32 = 10'sd127;
  localparam logic signed [9:0] BIAS16 = 10'sd15;

  localparam logic signed [7:0] EXP_MIN_RST = -8'sd8;
  localparam logic signed [7:0] EXP_MAX_RST = 8'sd7;
  localparam logic [3:0]        MANT_BITS_RST = 4'd8;
  localparam logic              HALF_RST = 1'b0;
  localparam logic              FRAC_RST = 1'b1;

  typedef enum logic {
    OP_CONVERT = 1'b0,
    OP_WRITE   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CLS_IN_RANGE  = 2'd0,
    CLS_ZERO_NEG  = 2'd1,
    CLS_UNDERFLOW = 2'd2,
    CLS_OVERFLOW  = 2'd3
  } range_class_t;

  typedef enum logic [2:0] {
    REG_EXP_MIN   = 3'd0,
    REG_EXP_MAX   = 3'd1,
    REG_MANT_BITS = 3'd2,
    REG_HALF      = 3'd3,
    REG_FRAC      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [7:0] exp_min;
    logic signed [7:0] exp_max;
    logic [3:0]        mantissa_bits;
    logic              half_format;
    logic              include_fraction;
  } cfg_t;

  // Decoded sample, carried from the lookup stage to the compose stage
  typedef struct packed {
    range_class_t       cls;
    logic [7:0]         exp_off;
    logic [3:0]         mb;
    logic [4:0]         shift;
    logic [MANT_W-1:0]  frac;
    logic               is_half;
  } dec_t;

endpackage

`default_nettype wire

@@ hdl/float_log_histogram_bin_top.sv @@
// Pipeline: a sample transfer registers its decode and table read, then the
// output register shows its bin on m_tdata. Table writes give no result.
// Throughput: one item per cycle unless stalled; each item uses the table
// RAM once, the write port for table writes and the read port for conversions.
// Reset: configuration returns to its defaults and the pipeline empties; the
// log table is not cleared and holds no defined value until written.
// ---------------------------------------------------------------------------
// float_log_histogram_bin_top
// Logarithmic histogram bin mapper for float32 and half samples.
// ---------------------------------------------------------------------------
`default_nettype none

module float_log_histogram_bin_top
  import flhb_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // APB configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [31:0] sample_bits, [41:32] entry_index, [51:42] entry_value, [55:52] zero
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  // [0] opcode
  input  wire logic                 s_tuser,
  // output stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [31:0] bin_index
  output logic      [M_TDATA_W-1:0] m_tdata,
  // [1:0] range_class
  output logic      [1:0]           m_tuser
);

  localparam int DEPTH = 1 << TABLE_ADDR_BITS;

  cfg_t                       cfg;
  dec_t                       dec;
  dec_t                       s1_dec;
  logic                       s1_valid;
  logic                       advance;
  logic                       take;
  logic                       take_conv;
  logic                       take_write;
  logic [TABLE_ADDR_BITS-1:0] rd_addr;
  logic [TABLE_ADDR_BITS-1:0] wr_addr;
  logic [25:0]                idx_ext;
  logic [ENTRY_W-1:0]         tbl_value;
  logic [31:0]                bin_index;
  range_class_t               range_class;

  flhb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  flhb_decode #(
    .ADDR_BITS (TABLE_ADDR_BITS)
  ) u_decode (
    .sample  (s_tdata[31:0]),
    .cfg     (cfg),
    .dec     (dec),
    .rd_addr (rd_addr)
  );

  // Output register frees stage 1 when empty or taken this cycle
  assign advance    = !m_tvalid || m_tready;
  assign s_tready   = !s1_valid || advance;
  assign take       = s_tvalid && s_tready;
  assign take_conv  = take && (opcode_t'(s_tuser) == OP_CONVERT);
  assign take_write = take && (opcode_t'(s_tuser) == OP_WRITE);

  assign idx_ext = {16'd0, s_tdata[41:32]};
  assign wr_addr = idx_ext[TABLE_ADDR_BITS-1:0];

  // Writes land at transfer, so a following conversion already reads them
  flhb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (take_write),
    .waddr (wr_addr),
    .wdata (s_tdata[51:42]),
    .re    (take_conv),
    .raddr (rd_addr),
    .rdata (tbl_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= take_conv;
    end
  end

  always_ff @(posedge clk) begin
    if (take_conv) begin
      s1_dec <= dec;
    end
  end

  flhb_compose u_compose (
    .dec              (s1_dec),
    .tbl_value        (tbl_value),
    .include_fraction (cfg.include_fraction),
    .bin_index        (bin_index),
    .range_class      (range_class)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= bin_index;
      m_tuser <= range_class;
    end
  end

endmodule

`default_nettype wire

@@ hdl/flhb_ram.sv @@
// ---------------------------------------------------------------------------
// flhb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module flhb_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/flhb_regs.sv @@
// ---------------------------------------------------------------------------
// flhb_regs
// APB configuration registers of the bin mapper.
// ---------------------------------------------------------------------------
`default_nettype none

module flhb_regs
  import flhb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exp_min          <= EXP_MIN_RST;
      cfg.exp_max          <= EXP_MAX_RST;
      cfg.mantissa_bits    <= MANT_BITS_RST;
      cfg.half_format      <= HALF_RST;
      cfg.include_fraction <= FRAC_RST;
    end else if (wr) begin
      case (idx)
        REG_EXP_MIN:   cfg.exp_min          <= pwdata[7:0];
        REG_EXP_MAX:   cfg.exp_max          <= pwdata[7:0];
        REG_MANT_BITS: cfg.mantissa_bits    <= pwdata[3:0];
        REG_HALF:      cfg.half_format      <= pwdata[0];
        REG_FRAC:      cfg.include_fraction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EXP_MIN:   prdata = {24'd0, cfg.exp_min};
      REG_EXP_MAX:   prdata = {24'd0, cfg.exp_max};
      REG_MANT_BITS: prdata = {28'd0, cfg.mantissa_bits};
      REG_HALF:      prdata = {31'd0, cfg.half_format};
      REG_FRAC:      prdata = {31'd0, cfg.include_fraction};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/flhb_decode.sv @@
// ---------------------------------------------------------------------------
// flhb_decode
// Splits a sample into class, exponent offset and mantissa; forms the table
// address.
// ---------------------------------------------------------------------------
`default_nettype none

module flhb_decode
  import flhb_pkg::*;
#(
  parameter int ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  wire logic [31:0]          sample,
  input  cfg_t                      cfg,
  output dec_t                      dec,
  output logic      [ADDR_BITS-1:0] rd_addr
);

  logic                zero_neg;
  logic [7:0]          exp_field;
  logic [MANT_W-1:0]   mant;
  logic [4:0]          width;
  logic signed [9:0]   bias;
  logic signed [9:0]   e;
  logic signed [9:0]   emin;
  logic signed [9:0]   emax;
  logic signed [9:0]   d_in;
  logic signed [9:0]   d_span;
  logic                under;
  logic                over;
  logic [3:0]          mb;
  logic [4:0]          shift;
  logic [MANT_W-1:0]   mant_sh;
  logic [MANT_W-1:0]   frac_mask;

  always_comb begin
    if (cfg.half_format) begin
      zero_neg  = ((sample[15:0] & SIGN16) != 16'd0) || (sample[15:0] == 16'd0);
      exp_field = {3'd0, sample[14:10]};
      mant      = {13'd0, sample[9:0]};
      width     = WIDTH16;
      bias      = BIAS16;
    end else begin
      zero_neg  = ((sample & SIGN32) != 32'd0) || (sample == 32'd0);
      exp_field = sample[30:23];
      mant      = sample[22:0];
      width     = WIDTH32;
      bias      = BIAS32;
    end

    e      = $signed({2'b00, exp_field}) - bias;
    emin   = {{2{cfg.exp_min[7]}}, cfg.exp_min};
    emax   = {{2{cfg.exp_max[7]}}, cfg.exp_max};
    under  = e < emin;
    over   = e > emax;
    d_in   = e - emin;
    d_span = emax - emin;

    // clamp the log mantissa width to the format's mantissa
    mb = ({1'b0, cfg.mantissa_bits} > width) ? width[3:0] : cfg.mantissa_bits;
    shift = width - {1'b0, mb};

    mant_sh   = mant >> shift;
    frac_mask = ~({MANT_W{1'b1}} << shift);
    rd_addr   = mant_sh[ADDR_BITS-1:0];

    dec.is_half = cfg.half_format;
    dec.mb      = mb;
    dec.shift   = shift;
    dec.frac    = over ? frac_mask : (mant & frac_mask);
    if (over) begin
      dec.exp_off = d_span[9] ? 8'd0 : d_span[7:0];
    end else begin
      dec.exp_off = d_in[7:0];
    end

    if (zero_neg) begin
      dec.cls = CLS_ZERO_NEG;
    end else if (under) begin
      dec.cls = CLS_UNDERFLOW;
    end else if (over) begin
      dec.cls = CLS_OVERFLOW;
    end else begin
      dec.cls = CLS_IN_RANGE;
    end
  end

endmodule

`default_nettype wire

@@ hdl/flhb_compose.sv @@
// ---------------------------------------------------------------------------
// flhb_compose
// Merges exponent offset, table value and fraction into the bin index.
// ---------------------------------------------------------------------------
`default_nettype none

module flhb_compose
  import flhb_pkg::*;
(
  input  dec_t                    dec,
  input  wire logic [ENTRY_W-1:0] tbl_value,
  input  wire logic               include_fraction,
  output logic      [31:0]        bin_index,
  output range_class_t            range_class
);

  logic [14:0] mb_mask;
  logic [14:0] mant_bits;
  logic [4:0]  width;
  logic [31:0] with_frac;
  logic [31:0] no_frac;

  always_comb begin
    mb_mask   = ~(15'h7FFF << dec.mb);
    mant_bits = (dec.cls == CLS_OVERFLOW) ? mb_mask : ({5'd0, tbl_value} & mb_mask);
    width     = dec.is_half ? WIDTH16 : WIDTH32;

    // mb + shift equals the format width, so the exponent lands at width
    with_frac = ({24'd0, dec.exp_off} << width)
              | ({17'd0, mant_bits} << dec.shift)
              | {9'd0, dec.frac};
    no_frac   = ({24'd0, dec.exp_off} << dec.mb) | {17'd0, mant_bits};

    range_class = dec.cls;
    if ((dec.cls == CLS_ZERO_NEG) || (dec.cls == CLS_UNDERFLOW)) begin
      bin_index = 32'd0;
    end else if (include_fraction) begin
      bin_index = with_frac;
    end else begin
      bin_index = no_frac;
    end
  end

endmodule

`default_nettype wire

@@ hdl/flhb_checker.sv @@
// ---------------------------------------------------------------------------
// flhb_checker
// Port-level assertions on the bin mapper, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module flhb_checker
  import flhb_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [1:0]           m_tuser
);

  `FLHB_ASSERT_RST(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")

  `FLHB_ASSERT_RST(a_rst_ready, clk, rst |=> s_tready, "input not ready after reset")

  `FLHB_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  `FLHB_ASSERT(a_zero_bin, clk, rst, m_tvalid && (m_tuser == CLS_ZERO_NEG || m_tuser == CLS_UNDERFLOW) |-> m_tdata == '0, "non-zero bin for zero or underflow")

endmodule

bind float_log_histogram_bin_top flhb_checker u_flhb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
